>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked, disabled during active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define RUSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define RUSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rusi_pkg.sv
// ----------------------------------------------------------------------------
// rusi_pkg
// shared types and constants of the ray / unit sphere intersection pipeline
// ----------------------------------------------------------------------------
package rusi_pkg;

    // coordinate word and fixed-point format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // digit width of the pipelined multipliers
    localparam int MUL_DIGIT_W = 16;

    typedef enum logic [1:0] {
        KIND_MISS     = 2'd0,
        KIND_TANGENT  = 2'd1,
        KIND_TWO      = 2'd2,
        KIND_ZERO_DIR = 2'd3
    } t_hit_kind;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic signed [COORD_WIDTH-1:0] start_time;
    } t_ray_in;

    typedef struct packed {
        t_hit_kind                     hit_kind;
        logic signed [COORD_WIDTH-1:0] t_near;
        logic signed [COORD_WIDTH-1:0] t_far;
        logic                          saturated;
    } t_hit_out;

endpackage

>>> src/rusi_mul.sv
// ----------------------------------------------------------------------------
// rusi_mul
// pipelined signed multiplier, one digit of the second operand per stage
// ----------------------------------------------------------------------------
module rusi_mul #(
    parameter int A_W     = rusi_pkg::COORD_WIDTH,
    parameter int B_W     = rusi_pkg::COORD_WIDTH,
    parameter int DIGIT_W = rusi_pkg::MUL_DIGIT_W
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_p
);

    localparam int ND  = (B_W + DIGIT_W - 1) / DIGIT_W;
    localparam int BX  = ND * DIGIT_W;
    localparam int P_W = A_W + B_W;

    logic signed [A_W-1:0]       r_a   [ND];
    logic        [BX-1:0]        r_b   [ND];
    logic signed [P_W-1:0]       r_acc [ND];
    logic signed [A_W-1:0]       w_a   [ND];
    logic        [BX-1:0]        w_b   [ND];
    logic signed [P_W-1:0]       w_acc [ND];
    logic signed [P_W-1:0]       n_acc [ND];

    always_comb begin
        logic        [DIGIT_W-1:0] dig;
        logic signed [DIGIT_W:0]   dig_s;
        logic signed [A_W+DIGIT_W:0] pp;
        w_a[0]   = i_a;
        w_b[0]   = BX'(i_b);
        w_acc[0] = '0;
        for (int k = 1; k < ND; k++) begin
            w_a[k]   = r_a[k-1];
            w_b[k]   = r_b[k-1];
            w_acc[k] = r_acc[k-1];
        end
        for (int k = 0; k < ND; k++) begin
            dig = w_b[k][k*DIGIT_W +: DIGIT_W];
            // only the top digit carries the sign
            if (k == ND - 1) begin
                dig_s = $signed({dig[DIGIT_W-1], dig});
            end else begin
                dig_s = $signed({1'b0, dig});
            end
            pp       = w_a[k] * dig_s;
            n_acc[k] = w_acc[k] + (P_W'(pp) <<< (k * DIGIT_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ND; k++) begin
                r_a[k]   <= w_a[k];
                r_b[k]   <= w_b[k];
                r_acc[k] <= n_acc[k];
            end
        end
    end

    assign o_p = r_acc[ND-1];

endmodule

>>> src/ray_unit_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect
// fully pipelined ray against unit-radius sphere test; while not stalled, one ray per cycle
// ----------------------------------------------------------------------------
// usage
//   input channel : i_in_valid / o_in_stall carry one ray (origin, direction,
//                   start time, sphere center) per transfer, signed fixed point
//   output channel: o_out_valid / i_out_stall carry one result per ray: hit
//                   kind, near and far roots, saturation flag
//   throughput    : one transfer per cycle on each side while not stalled
//   depth         : set mainly by the square root (one root bit per stage) and
//                   the two dividers (one quotient bit per stage)
//   reset         : clears every stage valid bit, no result is shown after it
//   stall         : a stalled result freezes the whole pipeline in place and
//                   raises o_in_stall; nothing is lost or repeated
// ----------------------------------------------------------------------------
module ray_unit_sphere_intersect #(
    parameter int FRAC_BITS = rusi_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rusi_pkg::t_ray_in   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rusi_pkg::t_hit_out  o_out_data
);

    // widths along the datapath
    localparam int W    = rusi_pkg::COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int D    = rusi_pkg::MUL_DIGIT_W;
    localparam int L1   = (W + D - 1) / D;       // start_time * dir
    localparam int SUMW = 2 * W - F + 1;          // origin plus shifted product
    localparam int QW   = W + 1;                  // p - center
    localparam int L2   = (QW + D - 1) / D;       // dot product terms
    localparam int PW2  = 2 * QW;
    localparam int SW   = PW2 + 2;                // a, h, c
    localparam int L3   = (SW + D - 1) / D;       // h*h and a*c
    localparam int DW   = 2 * SW;                 // discriminant
    localparam int RW   = SW;                     // root
    localparam int RMW  = RW + 3;                 // root remainder
    localparam int NS   = SW + 2;                 // -h -/+ root
    localparam int NW   = NS + F;                 // scaled numerator magnitude
    localparam int XW   = NW + W;                 // divider compare width
    localparam int TL   = L1 + 2 + L2 + 1 + L3 + 1 + RW + 3 + W + 1;

    localparam logic signed [SW-1:0] ONE_SQ = SW'(1) << (2 * F);
    localparam logic [W-1:0]         MAX_V  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]         MIN_V  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]           HALF_V = (W+1)'(1) << (W - 1);

    typedef logic [2:0][W-1:0] t_vec3;

    typedef struct packed {
        t_vec3 org;
        t_vec3 dir;
        t_vec3 ctr;
    } t_seg1;

    typedef struct packed {
        logic [SW-1:0] a;
        logic [SW-1:0] h;
    } t_seg5;

    // global advance: the whole pipe moves unless a result waits on a stall
    logic w_en;
    logic r_vld [TL];

    assign w_en        = !r_vld[TL-1] || !i_out_stall;
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[TL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TL; s++) r_vld[s] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < TL; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // ------------------------------------------------------------------
    // advance the origin: start_time * dir
    // ------------------------------------------------------------------
    t_seg1                 w_s1_in;
    t_seg1                 r_s1 [L1];
    logic signed [2*W-1:0] w_td [3];

    always_comb begin
        w_s1_in.org = {i_in_data.origin_z, i_in_data.origin_y, i_in_data.origin_x};
        w_s1_in.dir = {i_in_data.dir_z, i_in_data.dir_y, i_in_data.dir_x};
        w_s1_in.ctr = {i_in_data.center_z, i_in_data.center_y, i_in_data.center_x};
    end

    for (genvar k = 0; k < 3; k++) begin : g_mul_td
        rusi_mul #(.A_W(W), .B_W(W), .DIGIT_W(D)) u_mul_td (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (i_in_data.start_time),
            .i_b   ($signed(w_s1_in.dir[k])),
            .o_p   (w_td[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1[0] <= w_s1_in;
            for (int s = 1; s < L1; s++) r_s1[s] <= r_s1[s-1];
        end
    end

    // p = clamp(origin + floor(t*d / 2^F)), then q = p - center
    logic signed [SUMW-1:0] w_psum [3];
    t_vec3                  w_p;
    t_vec3                  r_p;
    t_vec3                  r_dir2;
    t_vec3                  r_ctr2;
    logic signed [QW-1:0]   r_q  [3];
    logic signed [QW-1:0]   r_dq [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_psum[k] = SUMW'($signed(r_s1[L1-1].org[k])) + SUMW'(w_td[k] >>> F);
            // upper bits all equal means the sum fits the coordinate word
            if ((&w_psum[k][SUMW-1:W-1]) || !(|w_psum[k][SUMW-1:W-1])) begin
                w_p[k] = w_psum[k][W-1:0];
            end else if (w_psum[k][SUMW-1]) begin
                w_p[k] = MIN_V;
            end else begin
                w_p[k] = MAX_V;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p    <= w_p;
            r_dir2 <= r_s1[L1-1].dir;
            r_ctr2 <= r_s1[L1-1].ctr;
            for (int k = 0; k < 3; k++) begin
                r_q[k]  <= QW'($signed(r_p[k])) - QW'($signed(r_ctr2[k]));
                r_dq[k] <= QW'($signed(r_dir2[k]));
            end
        end
    end

    // ------------------------------------------------------------------
    // dot products: a = d.d, h = d.q, c = q.q - 1
    // ------------------------------------------------------------------
    logic signed [PW2-1:0] w_dd [3];
    logic signed [PW2-1:0] w_dqp [3];
    logic signed [PW2-1:0] w_qq [3];

    for (genvar k = 0; k < 3; k++) begin : g_mul_dot
        rusi_mul #(.A_W(QW), .B_W(QW), .DIGIT_W(D)) u_mul_dd (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_dq[k]),
            .i_b   (r_dq[k]),
            .o_p   (w_dd[k])
        );
        rusi_mul #(.A_W(QW), .B_W(QW), .DIGIT_W(D)) u_mul_dq (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_q[k]),
            .i_b   (r_dq[k]),
            .o_p   (w_dqp[k])
        );
        rusi_mul #(.A_W(QW), .B_W(QW), .DIGIT_W(D)) u_mul_qq (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_q[k]),
            .i_b   (r_q[k]),
            .o_p   (w_qq[k])
        );
    end

    logic signed [SW-1:0] r_a4;
    logic signed [SW-1:0] r_h4;
    logic signed [SW-1:0] r_c4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a4 <= SW'(w_dd[0]) + SW'(w_dd[1]) + SW'(w_dd[2]);
            r_h4 <= SW'(w_dqp[0]) + SW'(w_dqp[1]) + SW'(w_dqp[2]);
            r_c4 <= SW'(w_qq[0]) + SW'(w_qq[1]) + SW'(w_qq[2]) - ONE_SQ;
        end
    end

    // ------------------------------------------------------------------
    // discriminant h*h - a*c (quarter of b*b - 4ac, same sign)
    // ------------------------------------------------------------------
    logic signed [DW-1:0] w_hh;
    logic signed [DW-1:0] w_ac;
    t_seg5                r_s5 [L3];

    rusi_mul #(.A_W(SW), .B_W(SW), .DIGIT_W(D)) u_mul_hh (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_h4),
        .i_b   (r_h4),
        .o_p   (w_hh)
    );

    rusi_mul #(.A_W(SW), .B_W(SW), .DIGIT_W(D)) u_mul_ac (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_a4),
        .i_b   (r_c4),
        .o_p   (w_ac)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5[0].a <= r_a4;
            r_s5[0].h <= r_h4;
            for (int s = 1; s < L3; s++) r_s5[s] <= r_s5[s-1];
        end
    end

    logic signed [DW-1:0] w_disc;
    rusi_pkg::t_hit_kind  w_kind6;
    logic [DW-1:0]        r_rad6;
    logic [SW-1:0]        r_h6;
    logic [SW-1:0]        r_a6;
    rusi_pkg::t_hit_kind  r_kind6;

    always_comb begin
        w_disc = w_hh - w_ac;
        if (r_s5[L3-1].a == '0) begin
            w_kind6 = rusi_pkg::KIND_ZERO_DIR;
        end else if (w_disc[DW-1]) begin
            w_kind6 = rusi_pkg::KIND_MISS;
        end else if (w_disc == '0) begin
            w_kind6 = rusi_pkg::KIND_TANGENT;
        end else begin
            w_kind6 = rusi_pkg::KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // no root needed on a miss or a zero direction
            r_rad6  <= (w_kind6 == rusi_pkg::KIND_TWO) ? w_disc : '0;
            r_h6    <= r_s5[L3-1].h;
            r_a6    <= r_s5[L3-1].a;
            r_kind6 <= w_kind6;
        end
    end

    // ------------------------------------------------------------------
    // integer square root, one root bit per stage
    // ------------------------------------------------------------------
    logic [DW-1:0]       r_srad  [RW];
    logic [RMW-1:0]      r_srem  [RW];
    logic [RW-1:0]       r_sroot [RW];
    logic [SW-1:0]       r_sh    [RW];
    logic [SW-1:0]       r_sa    [RW];
    rusi_pkg::t_hit_kind r_skind [RW];
    logic [DW-1:0]       w_srad_in  [RW];
    logic [RMW-1:0]      w_srem_in  [RW];
    logic [RW-1:0]       w_sroot_in [RW];
    logic [RMW-1:0]      n_srem  [RW];
    logic [RW-1:0]       n_sroot [RW];

    always_comb begin
        logic [RMW-1:0] shifted;
        logic [RMW-1:0] trial;
        w_srad_in[0]  = r_rad6;
        w_srem_in[0]  = '0;
        w_sroot_in[0] = '0;
        for (int k = 1; k < RW; k++) begin
            w_srad_in[k]  = r_srad[k-1];
            w_srem_in[k]  = r_srem[k-1];
            w_sroot_in[k] = r_sroot[k-1];
        end
        for (int k = 0; k < RW; k++) begin
            shifted = {w_srem_in[k][RMW-3:0], w_srad_in[k][DW-1 -: 2]};
            trial   = {1'b0, w_sroot_in[k], 2'b01};
            if (shifted >= trial) begin
                n_srem[k]  = shifted - trial;
                n_sroot[k] = {w_sroot_in[k][RW-2:0], 1'b1};
            end else begin
                n_srem[k]  = shifted;
                n_sroot[k] = {w_sroot_in[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sh[0]    <= r_h6;
            r_sa[0]    <= r_a6;
            r_skind[0] <= r_kind6;
            for (int k = 1; k < RW; k++) begin
                r_sh[k]    <= r_sh[k-1];
                r_sa[k]    <= r_sa[k-1];
                r_skind[k] <= r_skind[k-1];
            end
            for (int k = 0; k < RW; k++) begin
                r_srad[k]  <= w_srad_in[k] << 2;
                r_srem[k]  <= n_srem[k];
                r_sroot[k] <= n_sroot[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // numerators 2^F * (-h -/+ r): sum, magnitude, range check
    // lane 0 is the near root, lane 1 the far root
    // ------------------------------------------------------------------
    logic signed [NS-1:0] r_n8 [2];
    logic [SW-1:0]        r_a8;
    rusi_pkg::t_hit_kind  r_kind8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n8[0] <= -NS'($signed(r_sh[RW-1])) - NS'(r_sroot[RW-1]);
            r_n8[1] <= -NS'($signed(r_sh[RW-1])) + NS'(r_sroot[RW-1]);
            r_a8    <= r_sa[RW-1];
            r_kind8 <= r_skind[RW-1];
        end
    end

    logic [1:0][NW-1:0]  r_mag9;
    logic [1:0]          r_neg9;
    logic [SW-1:0]       r_a9;
    rusi_pkg::t_hit_kind r_kind9;

    always_ff @(posedge i_clk) begin
        logic [NS-1:0] absval;
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                absval    = r_n8[l][NS-1] ? NS'(-r_n8[l]) : NS'(r_n8[l]);
                r_mag9[l] <= NW'(absval) << F;
                r_neg9[l] <= r_n8[l][NS-1];
            end
            r_a9    <= r_a8;
            r_kind9 <= r_kind8;
        end
    end

    logic [1:0][NW-1:0]  r_rem10;
    logic [1:0]          r_neg10;
    logic [1:0]          r_ovf10;
    logic [SW-1:0]       r_a10;
    rusi_pkg::t_hit_kind r_kind10;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                // quotient of 2^W or more cannot fit the result word
                r_ovf10[l] <= XW'(r_mag9[l]) >= (XW'(r_a9) << W);
            end
            r_rem10  <= r_mag9;
            r_neg10  <= r_neg9;
            r_a10    <= r_a9;
            r_kind10 <= r_kind9;
        end
    end

    // ------------------------------------------------------------------
    // restoring dividers, one quotient bit per stage, both lanes
    // ------------------------------------------------------------------
    logic [1:0][NW-1:0]  r_drem  [W];
    logic [1:0][W-1:0]   r_dquo  [W];
    logic [1:0]          r_dneg  [W];
    logic [1:0]          r_dovf  [W];
    logic [SW-1:0]       r_da    [W];
    rusi_pkg::t_hit_kind r_dkind [W];
    logic [1:0][NW-1:0]  w_drem_in [W];
    logic [1:0][W-1:0]   w_dquo_in [W];
    logic [SW-1:0]       w_da_in   [W];
    logic [1:0][NW-1:0]  n_drem [W];
    logic [1:0][W-1:0]   n_dquo [W];

    always_comb begin
        logic [XW-1:0] sub;
        w_drem_in[0] = r_rem10;
        w_dquo_in[0] = '0;
        w_da_in[0]   = r_a10;
        for (int k = 1; k < W; k++) begin
            w_drem_in[k] = r_drem[k-1];
            w_dquo_in[k] = r_dquo[k-1];
            w_da_in[k]   = r_da[k-1];
        end
        for (int k = 0; k < W; k++) begin
            sub = XW'(w_da_in[k]) << (W - 1 - k);
            for (int l = 0; l < 2; l++) begin
                if (XW'(w_drem_in[k][l]) >= sub) begin
                    n_drem[k][l] = w_drem_in[k][l] - sub[NW-1:0];
                    n_dquo[k][l] = {w_dquo_in[k][l][W-2:0], 1'b1};
                end else begin
                    n_drem[k][l] = w_drem_in[k][l];
                    n_dquo[k][l] = {w_dquo_in[k][l][W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dneg[0]  <= r_neg10;
            r_dovf[0]  <= r_ovf10;
            r_dkind[0] <= r_kind10;
            for (int k = 1; k < W; k++) begin
                r_dneg[k]  <= r_dneg[k-1];
                r_dovf[k]  <= r_dovf[k-1];
                r_dkind[k] <= r_dkind[k-1];
            end
            for (int k = 0; k < W; k++) begin
                r_drem[k] <= n_drem[k];
                r_dquo[k] <= n_dquo[k];
                r_da[k]   <= w_da_in[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // floor correction, clamp, zero fill on miss and zero direction
    // ------------------------------------------------------------------
    rusi_pkg::t_hit_out n_out;
    rusi_pkg::t_hit_out r_out;

    always_comb begin
        logic [W:0]        mag;
        logic [1:0][W-1:0] tval;
        logic [1:0]        sat;
        for (int l = 0; l < 2; l++) begin
            mag     = '0;
            sat[l]  = 1'b0;
            tval[l] = r_dquo[W-1][l];
            if (!r_dneg[W-1][l]) begin
                if (r_dovf[W-1][l] || r_dquo[W-1][l][W-1]) begin
                    sat[l]  = 1'b1;
                    tval[l] = MAX_V;
                end
            end else begin
                // negative numerator rounds away from zero when inexact
                mag = {1'b0, r_dquo[W-1][l]} + (W+1)'(r_drem[W-1][l] != '0);
                if (r_dovf[W-1][l] || (mag > HALF_V)) begin
                    sat[l]  = 1'b1;
                    tval[l] = MIN_V;
                end else begin
                    tval[l] = ~mag[W-1:0] + W'(1);
                end
            end
        end
        n_out.hit_kind = r_dkind[W-1];
        if ((r_dkind[W-1] == rusi_pkg::KIND_TANGENT) || (r_dkind[W-1] == rusi_pkg::KIND_TWO)) begin
            n_out.t_near    = $signed(tval[0]);
            n_out.t_far     = $signed(tval[1]);
            n_out.saturated = |sat;
        end else begin
            n_out.t_near    = '0;
            n_out.t_far     = '0;
            n_out.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> src/rusi_checker.sv
// ----------------------------------------------------------------------------
// rusi_checker
// port-level checks of the intersection pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rusi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input rusi_pkg::t_ray_in  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rusi_pkg::t_hit_out o_out_data
);

    logic w_no_roots;
    logic w_roots;

    assign w_no_roots = (o_out_data.hit_kind == rusi_pkg::KIND_MISS) ||
                        (o_out_data.hit_kind == rusi_pkg::KIND_ZERO_DIR);
    assign w_roots    = (o_out_data.hit_kind == rusi_pkg::KIND_TANGENT) ||
                        (o_out_data.hit_kind == rusi_pkg::KIND_TWO);

    // a held result stays put
    `RUSI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // input stalls only behind a stalled result
    `RUSI_ASSERT(a_in_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without output stall")

    // no roots reported on miss or zero direction
    `RUSI_ASSERT(a_zero_fill, i_clk, i_rst_n, (o_out_valid && w_no_roots) |-> ((o_out_data.t_near == '0) && (o_out_data.t_far == '0) && !o_out_data.saturated), "nonzero roots without hit")

    // roots come ordered
    `RUSI_ASSERT(a_root_order, i_clk, i_rst_n, (o_out_valid && w_roots) |-> ($signed(o_out_data.t_near) <= $signed(o_out_data.t_far)), "near root above far root")

endmodule

bind ray_unit_sphere_intersect rusi_checker u_rusi_checker (.*);
